// ----- rtl/bis_pkg.sv -----
// types and constants shared by the block index search unit
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;

    localparam int CMD_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int KEY_W      = 32;
    localparam int SLOT_W     = 10;
    localparam int BSLOT_W    = 6;
    localparam int IDX_W      = KEY_W + SLOT_W;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE_ELEMENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_INDEX   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH        = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAIN_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_COUNT = 2'd1;

    localparam logic [10:0] MAIN_LENGTH_RESET = 11'd1024;
    localparam logic [6:0]  INDEX_COUNT_RESET = 7'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_GOT_FIRST,
        S_GOT_NEXT,
        S_SCAN_CHK,
        S_SCAN_CMP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/bis_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/block_index_search_unit.sv -----
// block index search unit: index binary search then block scan over main ram
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: cmd, tdata: load and search fields
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: found, position
//  cfg       in   i_cfg_we                       i_cfg_addr, i_cfg_data
//
// loads are written as they are accepted. a search makes at most log2(index_count) + 1
// index probes, then scans the elements of the chosen block; each probe and each
// element costs one registered read of the index ram or the main ram. stores need no
// clearing after reset.
// a result waits in the output register; new words are taken while it waits,
// and a following search holds in its last state until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module block_index_search_unit #(
    parameter int MAIN_DEPTH  = 1024,
    parameter int INDEX_DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] element_slot, [41:10] element_value, [47:42] block_slot,
    // [79:48] block_max_key, [89:80] block_start, [121:90] search_key
    input  wire logic [bis_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] cmd
    input  wire logic [bis_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] found, [10:1] position
    output logic      [bis_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [bis_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import bis_pkg::*;

    localparam int MAW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int PW  = (MAW > 11) ? MAW : 11;
    localparam int CW  = (IAW > 7) ? IAW : 7;

    logic [SLOT_W-1:0]  w_elem_slot;
    logic [KEY_W-1:0]   w_elem_value;
    logic [BSLOT_W-1:0] w_blk_slot;
    logic [KEY_W-1:0]   w_blk_key;
    logic [SLOT_W-1:0]  w_blk_start;
    logic [KEY_W-1:0]   w_search_key;

    assign w_elem_slot  = s_axis_tdata[9:0];
    assign w_elem_value = s_axis_tdata[41:10];
    assign w_blk_slot   = s_axis_tdata[47:42];
    assign w_blk_key    = s_axis_tdata[79:48];
    assign w_blk_start  = s_axis_tdata[89:80];
    assign w_search_key = s_axis_tdata[121:90];

    t_state r_state, n_state;
    logic [10:0]       r_main_length;
    logic [6:0]        r_index_count;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]     r_lo, n_lo, r_hx, n_hx, r_mid, n_mid, r_cnt, n_cnt;
    logic [PW-1:0]     r_len, n_len, r_pos, n_pos, r_end, n_end;
    logic              r_res_found, n_res_found;
    logic [SLOT_W-1:0] r_res_pos, n_res_pos;
    logic              r_out_valid;
    logic              r_out_found;
    logic [SLOT_W-1:0] r_out_pos;

    logic              w_accept;
    logic              w_out_free;
    logic [CW:0]       w_sum;
    logic [CW-1:0]     w_mid;
    logic [CW-1:0]     w_lo_next;
    logic [CW-1:0]     w_cnt_clamp;
    logic [PW-1:0]     w_len_clamp;
    logic [PW-1:0]     w_q_start;
    logic signed [KEY_W-1:0] w_q_key;

    logic              w_main_we;
    logic [MAW-1:0]    w_main_waddr;
    logic [MAW-1:0]    w_main_raddr;
    logic [KEY_W-1:0]  w_main_q;
    logic              w_idx_we;
    logic [IAW-1:0]    w_idx_waddr;
    logic [IAW-1:0]    w_idx_raddr;
    logic [IDX_W-1:0]  w_idx_q;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hx} - {{CW{1'b0}}, 1'b1};
    assign w_mid     = w_sum[CW:1];
    assign w_lo_next = r_lo + {{(CW-1){1'b0}}, 1'b1};
    assign w_q_key   = w_idx_q[KEY_W-1:0];
    assign w_q_start = PW'(w_idx_q[IDX_W-1:KEY_W]);

    assign w_cnt_clamp = (32'(r_index_count) < INDEX_DEPTH) ? CW'(r_index_count)
                                                            : CW'(INDEX_DEPTH);
    assign w_len_clamp = (32'(r_main_length) < MAIN_DEPTH) ? PW'(r_main_length)
                                                           : PW'(MAIN_DEPTH);

    assign w_main_we    = w_accept && (s_axis_tuser == CMD_WRITE_ELEMENT)
                          && (32'(w_elem_slot) < MAIN_DEPTH);
    assign w_main_waddr = MAW'(w_elem_slot);
    assign w_main_raddr = r_pos[MAW-1:0];
    assign w_idx_we     = w_accept && (s_axis_tuser == CMD_WRITE_INDEX)
                          && (32'(w_blk_slot) < INDEX_DEPTH);
    assign w_idx_waddr  = IAW'(w_blk_slot);

    bis_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAIN_DEPTH)
    ) u_main_ram (
        .i_clk  (i_clk),
        .i_we   (w_main_we),
        .i_waddr(w_main_waddr),
        .i_wdata(w_elem_value),
        .i_raddr(w_main_raddr),
        .o_rdata(w_main_q)
    );

    bis_ram #(
        .WIDTH(IDX_W),
        .DEPTH(INDEX_DEPTH)
    ) u_index_ram (
        .i_clk  (i_clk),
        .i_we   (w_idx_we),
        .i_waddr(w_idx_waddr),
        .i_wdata({w_blk_start, w_blk_key}),
        .i_raddr(w_idx_raddr),
        .o_rdata(w_idx_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (s_axis_tuser == CMD_SEARCH)) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hx) begin
                    n_state = S_CMP;
                end else if (r_lo < r_cnt) begin
                    n_state = S_GOT_FIRST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: n_state = S_PROBE;
            S_GOT_FIRST: begin
                if (r_lo == r_cnt - {{(CW-1){1'b0}}, 1'b1}) begin
                    n_state = S_SCAN_CHK;
                end else begin
                    n_state = S_GOT_NEXT;
                end
            end
            S_GOT_NEXT: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (r_pos < r_end) begin
                    n_state = S_SCAN_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_CMP: begin
                if (w_main_q == r_key) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram addressing
    always_comb begin
        n_key       = r_key;
        n_lo        = r_lo;
        n_hx        = r_hx;
        n_mid       = r_mid;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_pos       = r_pos;
        n_end       = r_end;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        w_idx_raddr = w_mid[IAW-1:0];
        case (r_state)
            S_IDLE: begin
                n_key       = w_search_key;
                n_lo        = '0;
                n_hx        = w_cnt_clamp;
                n_cnt       = w_cnt_clamp;
                n_len       = w_len_clamp;
                n_res_found = 1'b0;
                n_res_pos   = '0;
            end
            S_PROBE: begin
                n_mid = w_mid;
                if (r_lo < r_hx) begin
                    w_idx_raddr = w_mid[IAW-1:0];
                end else begin
                    w_idx_raddr = r_lo[IAW-1:0];
                end
            end
            S_CMP: begin
                if (r_key <= w_q_key) begin
                    n_hx = r_mid;
                end else begin
                    n_lo = r_mid + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            S_GOT_FIRST: begin
                w_idx_raddr = w_lo_next[IAW-1:0];
                n_pos       = w_q_start;
                n_end       = r_len;
            end
            S_GOT_NEXT: begin
                n_end = (w_q_start < r_len) ? w_q_start : r_len;
            end
            S_SCAN_CMP: begin
                if (w_main_q == r_key) begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_pos[SLOT_W-1:0];
                end else begin
                    n_pos = r_pos + {{(PW-1){1'b0}}, 1'b1};
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_main_length <= MAIN_LENGTH_RESET;
            r_index_count <= INDEX_COUNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAIN_LENGTH: r_main_length <= i_cfg_data;
                    CFG_INDEX_COUNT: r_index_count <= i_cfg_data[6:0];
                    default:         r_index_count <= r_index_count;
                endcase
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_hx        <= n_hx;
        r_mid       <= n_mid;
        r_cnt       <= n_cnt;
        r_len       <= n_len;
        r_pos       <= n_pos;
        r_end       <= n_end;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - SLOT_W - 1){1'b0}}, r_out_pos, r_out_found};

    a_search_starts_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == CMD_SEARCH)) |=> (r_state == S_PROBE))
        else $error("search word did not start the index probe");

    a_probe_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo <= r_hx) && (r_hx <= r_cnt))
        else $error("binary search bounds crossed");

    a_scan_read_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP) |-> ($past(r_state) == S_SCAN_CHK) && (r_pos < r_end))
        else $error("scan compare without a matching main ram read");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// testbench for the block index search unit: directed table, then predicted random phases
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import bis_pkg::*;

    localparam logic [CMD_W-1:0]      CMD_UNUSED  = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED  = 2'd3;
    localparam int                    ITEM_TARGET = 1750;
    localparam int                    LOAD_SETTLE = 4;
    localparam int                    TAIL_CYCLES = 100;
    localparam logic signed [31:0]    KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0]    KEY_MAX     = 32'sh7fff_ffff;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [9:0]         element_slot;
        logic signed [31:0] element_value;
        logic [5:0]         block_slot;
        logic signed [31:0] block_max_key;
        logic [9:0]         block_start;
        logic signed [31:0] search_key;
    } t_lookup_word;

    typedef struct {
        logic       found;
        logic [9:0] position;
    } t_search_result;

    typedef enum {ROW_LOAD, ROW_TYPED, ROW_PREDICTED, ROW_CFG} t_row_kind;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    typedef struct {
        t_row_kind          kind;
        t_lookup_word       w;
        logic [CFG_ADDR_W-1:0] reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        logic               want_found;
        logic [9:0]         want_pos;
    } t_script_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [CMD_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // predictor state
    logic signed [31:0] main_mem [0:1023];
    bit                 main_wr [0:1023];
    logic signed [31:0] idx_key [0:63];
    logic [9:0]         idx_start [0:63];
    logic [10:0]        main_len_q  = MAIN_LENGTH_RESET;
    logic [6:0]         index_cnt_q = INDEX_COUNT_RESET;

    t_search_result awaited_lookups [$];
    t_script_row    script [$];
    int             mismatch_count = 0;
    int             words_sent     = 0;
    int             burst_left     = 0;
    logic [5:0]     rx_tick        = '0;
    t_rx_mode       rx_mode        = RX_OPEN;

    block_index_search_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_search_result predict_search(input logic signed [31:0] key);
        int len, cnt, lo, hi, mid, first, last, i;
        t_search_result r;
        len = (main_len_q > 11'd1024) ? 1024 : int'(main_len_q);
        cnt = (index_cnt_q > 7'd64) ? 64 : int'(index_cnt_q);
        lo = 0;
        hi = cnt - 1;
        r.found = 1'b0;
        r.position = '0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key <= idx_key[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        if (lo < cnt) begin
            first = int'(idx_start[lo]);
            last = (lo == cnt - 1) ? len - 1 : int'(idx_start[lo + 1]) - 1;
            if (last > len - 1) last = len - 1;
            for (i = first; i <= last && !r.found; i++) begin
                if (main_mem[i] == key) begin
                    r.found = 1'b1;
                    r.position = 10'(i);
                end
            end
        end
        return r;
    endfunction

    function automatic t_lookup_word random_word(input logic [CMD_W-1:0] cmd);
        t_lookup_word w;
        w.cmd = cmd;
        w.element_slot = 10'($urandom);
        w.element_value = $urandom;
        w.block_slot = 6'($urandom);
        w.block_max_key = $urandom;
        w.block_start = 10'($urandom);
        w.search_key = $urandom;
        return w;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [CMD_W-1:0] cmd,
                                    input int slot, input logic [31:0] val, input int start,
                                    input logic want_found = 1'b0, input int want_pos = 0);
        t_script_row r;
        r.kind = kind;
        r.w.cmd = cmd;
        r.w.element_slot = 10'(slot);
        r.w.element_value = val;
        r.w.block_slot = 6'(slot);
        r.w.block_max_key = val;
        r.w.block_start = 10'(start);
        r.w.search_key = val;
        r.reg_sel = '0;
        r.reg_val = '0;
        r.want_found = want_found;
        r.want_pos = 10'(want_pos);
        script.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] sel,
                                    input logic [CFG_DATA_W-1:0] value);
        t_script_row r;
        r.kind = ROW_CFG;
        r.w = random_word(CMD_UNUSED);
        r.reg_sel = sel;
        r.reg_val = value;
        r.want_found = 1'b0;
        r.want_pos = '0;
        script.push_back(r);
    endfunction

    // drive one word in bursts with random gaps, then fold it into the predictor
    task automatic send_word(input t_lookup_word w, input bit typed, input logic want_found,
                             input logic [9:0] want_pos);
        int gap;
        t_search_result want;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.cmd;
        s_axis_tdata  <= {6'b0, w.search_key, w.block_start, w.block_max_key, w.block_slot,
                          w.element_value, w.element_slot};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        case (w.cmd)
            CMD_WRITE_ELEMENT: begin
                main_mem[w.element_slot] = w.element_value;
                main_wr[w.element_slot] = 1'b1;
                words_sent++;
            end
            CMD_WRITE_INDEX: begin
                idx_key[w.block_slot] = w.block_max_key;
                idx_start[w.block_slot] = w.block_start;
                words_sent++;
            end
            CMD_SEARCH: begin
                want.found = want_found;
                want.position = want_pos;
                awaited_lookups.push_back(typed ? want : predict_search(w.search_key));
                words_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_lookups.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_MAIN_LENGTH) main_len_q = value;
        else if (sel == CFG_INDEX_COUNT) index_cnt_q = value[6:0];
    endtask

    // one setting of the registers, an array rewrite where needed, a fresh index, then searches
    task automatic run_phase(input int phase_no);
        int len_req, cnt_req, len_eff, cnt_eff, n_search, max_blk, pos, hi_b, r, i, b, k;
        bit tidy, rewrite, main_full;
        longint acc;
        logic signed [31:0] vmax, key;
        int starts [0:63];
        logic signed [31:0] keys [0:63];
        t_lookup_word w;
        main_full = 1'b1;
        for (i = 0; i < 1024; i++) if (!main_wr[i]) main_full = 1'b0;
        r = $urandom_range(0, 11);
        if (phase_no == 2) len_req = $urandom_range(0, 1) ? 2047 : 1024;
        else if (phase_no == 3) len_req = 1024;
        else if (r == 0) len_req = 0;
        else if (r == 1) len_req = 1;
        else if (r <= 3 && main_full) len_req = $urandom_range(129, 1024);
        else if (r == 4 && main_full) len_req = $urandom_range(1025, 2047);
        else len_req = $urandom_range(2, 64);
        r = $urandom_range(0, 9);
        if (phase_no == 2) cnt_req = 127;
        else if (phase_no == 3) cnt_req = $urandom_range(1, 2);
        else if (r == 0) cnt_req = 0;
        else if (r == 1) cnt_req = 1;
        else if (r == 2) cnt_req = 64;
        else if (r == 3) cnt_req = $urandom_range(65, 127);
        else cnt_req = $urandom_range(2, 16);
        len_eff = (len_req > 1024) ? 1024 : len_req;
        cnt_eff = (cnt_req > 64) ? 64 : cnt_req;
        tidy = (phase_no == 2 || phase_no == 3) ? 1'b1 : ($urandom_range(0, 3) != 0);

        cfg_write(CFG_MAIN_LENGTH, 11'(len_req));
        cfg_write(CFG_INDEX_COUNT, 11'(cnt_req));

        // main array: ascending with duplicates when tidy
        rewrite = (len_eff <= 256);
        for (i = 0; i < len_eff; i++) if (!main_wr[i]) rewrite = 1'b1;
        if (rewrite) begin
            acc = longint'($signed($urandom));
            if (acc > 64'sd2147483647 - 17 * len_eff) acc = 64'sd2147483647 - 17 * len_eff;
            for (i = 0; i < len_eff; i++) begin
                w = random_word(CMD_WRITE_ELEMENT);
                w.element_slot = 10'(i);
                if (tidy) w.element_value = 32'(acc);
                else if ($urandom_range(0, 1)) w.element_value = $urandom;
                else w.element_value = $urandom_range(0, 7);
                send_word(w, 1'b0, 1'b0, '0);
                acc += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            end
        end

        // index: non-decreasing starts and running block maxima when tidy
        pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
        for (b = 0; b < cnt_eff; b++) begin
            if (tidy) begin
                starts[b] = (pos > 1023) ? 1023 : pos;
                pos += $urandom_range(0, 2 * len_eff / cnt_eff + 1);
            end else if ($urandom_range(0, 3) == 0) begin
                starts[b] = $urandom_range(0, 1023);
            end else begin
                starts[b] = $urandom_range(0, len_eff + 8);
            end
        end
        max_blk = 0;
        for (b = 0; b < cnt_eff; b++) begin
            hi_b = (b == cnt_eff - 1) ? len_eff - 1 : starts[b + 1] - 1;
            if (hi_b > len_eff - 1) hi_b = len_eff - 1;
            if (hi_b - starts[b] + 1 > max_blk) max_blk = hi_b - starts[b] + 1;
            if (tidy) begin
                vmax = (b == 0) ? KEY_MIN : keys[b - 1];
                for (i = starts[b]; i <= hi_b; i++) if (main_mem[i] > vmax) vmax = main_mem[i];
                keys[b] = vmax;
            end else if (len_eff > 0 && $urandom_range(0, 1)) begin
                keys[b] = main_mem[$urandom_range(0, len_eff - 1)];
            end else begin
                keys[b] = $urandom;
            end
            w = random_word(CMD_WRITE_INDEX);
            w.block_slot = 6'(b);
            w.block_max_key = keys[b];
            w.block_start = 10'(starts[b]);
            send_word(w, 1'b0, 1'b0, '0);
        end

        n_search = (max_blk > 128) ? $urandom_range(2, 4) : $urandom_range(16, 48);
        for (k = 0; k < n_search; k++) begin
            // noise between searches only where the array stays short
            if (len_eff <= 128 && $urandom_range(0, 4) == 0) begin
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    w = random_word(CMD_WRITE_ELEMENT);
                    if (len_eff > 0 && $urandom_range(0, 1))
                        w.element_value = main_mem[$urandom_range(0, len_eff - 1)];
                end else if (r == 1) begin
                    w = random_word(CMD_WRITE_INDEX);
                    w.block_start = 10'($urandom_range(0, len_eff + 4));
                end else begin
                    w = random_word(CMD_UNUSED);
                end
                send_word(w, 1'b0, 1'b0, '0);
            end
            r = $urandom_range(0, 9);
            if (len_eff > 0 && r < 5) key = main_mem[$urandom_range(0, len_eff - 1)];
            else if (len_eff > 0 && r < 7)
                key = main_mem[$urandom_range(0, len_eff - 1)] +
                      ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
            else if (r == 7) key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            else key = $urandom;
            w = random_word(CMD_SEARCH);
            w.search_key = key;
            send_word(w, 1'b0, 1'b0, '0);
        end
    endtask

    // receiver stall pattern, switching mode each time the tick counter wraps
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == 6'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (rx_tick[2:0] == 3'd0);
            default:   m_axis_tready <= !m_axis_tready;
        endcase
    end

    always @(posedge i_clk) begin : check_result
        t_search_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (awaited_lookups.size() == 0) begin
                $display("%0t: unexpected word, expected none, got found=%0b position=%0d",
                         $time, m_axis_tdata[0], m_axis_tdata[10:1]);
                mismatch_count++;
            end else begin
                want = awaited_lookups.pop_front();
                if (m_axis_tdata[0] !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $time, want.found, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[10:1] !== want.position) begin
                    $display("%0t: position mismatch, expected %0d, got %0d",
                             $time, want.position, m_axis_tdata[10:1]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #250_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        // empty index
        add_row(ROW_TYPED, CMD_SEARCH, 0, 32'h0000_0000, 0, 1'b0, 0);
        add_row(ROW_TYPED, CMD_SEARCH, 0, KEY_MAX, 0, 1'b0, 0);
        add_row(ROW_LOAD, CMD_UNUSED, 1023, 32'hffff_ffff, 1023);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 0, KEY_MIN, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 1, 32'hffff_fffb, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 2, 32'h0000_0000, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 3, 32'd7, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 4, 32'd7, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 5, 32'd100, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 6, 32'd200, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 7, KEY_MAX, 0);
        add_row(ROW_LOAD, CMD_WRITE_ELEMENT, 1023, 32'h5a5a_a5a5, 0);
        add_row(ROW_LOAD, CMD_WRITE_INDEX, 0, 32'h0000_0000, 0);
        add_row(ROW_LOAD, CMD_WRITE_INDEX, 1, 32'd100, 3);
        add_row(ROW_LOAD, CMD_WRITE_INDEX, 2, KEY_MAX, 6);
        add_row(ROW_LOAD, CMD_WRITE_INDEX, 63, 32'hffff_ffff, 1023);
        add_cfg(CFG_MAIN_LENGTH, 11'd8);
        add_cfg(CFG_INDEX_COUNT, 11'd3);
        add_row(ROW_TYPED, CMD_SEARCH, 0, KEY_MIN, 0, 1'b1, 0);
        add_row(ROW_TYPED, CMD_SEARCH, 0, 32'd7, 0, 1'b1, 3);
        add_row(ROW_TYPED, CMD_SEARCH, 0, KEY_MAX, 0, 1'b1, 7);
        add_row(ROW_TYPED, CMD_SEARCH, 0, 32'd50, 0, 1'b0, 0);
        add_row(ROW_PREDICTED, CMD_SEARCH, 0, 32'hffff_fffb, 0);
        add_row(ROW_PREDICTED, CMD_SEARCH, 0, 32'd200, 0);
        // block end clamped to the array end
        add_cfg(CFG_MAIN_LENGTH, 11'd7);
        add_row(ROW_TYPED, CMD_SEARCH, 0, KEY_MAX, 0, 1'b0, 0);
        // key above every block
        add_cfg(CFG_INDEX_COUNT, 11'd2);
        add_row(ROW_TYPED, CMD_SEARCH, 0, 32'd150, 0, 1'b0, 0);
        // zero length array, and a write to no register
        add_cfg(CFG_MAIN_LENGTH, 11'd0);
        add_cfg(CFG_UNUSED, 11'h7ff);
        add_row(ROW_TYPED, CMD_SEARCH, 0, 32'hffff_fffb, 0, 1'b0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG)
                cfg_write(script[k].reg_sel, script[k].reg_val);
            else
                send_word(script[k].w, script[k].kind == ROW_TYPED, script[k].want_found,
                          script[k].want_pos);
        end

        phase_no = 0;
        while (words_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_lookups.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/bis_pkg.sv
rtl/bis_ram.sv
rtl/block_index_search_unit.sv
verif/testbench.sv
